>>> src/brb_pkg.sv
package brb_pkg;

    // Storage geometry
    localparam int DEPTH     = 1024;
    localparam int MAX_CHUNK = 8;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = 11;
    localparam int SUM_W     = CNT_W + 1;
    localparam int IDX_W     = $clog2(MAX_CHUNK + 1);
    localparam int SLOT_W    = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;
    localparam int DATA_W    = 64;

    // Operation codes
    localparam logic [2:0] MODE_ENQ    = 3'd0;
    localparam logic [2:0] MODE_DEQ    = 3'd1;
    localparam logic [2:0] MODE_PEEK   = 3'd2;
    localparam logic [2:0] MODE_SKIP   = 3'd3;
    localparam logic [2:0] MODE_COMMIT = 3'd4;
    localparam logic [2:0] MODE_CLEAR  = 3'd5;
    localparam logic [2:0] MODE_STATUS = 3'd6;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch an input beat
        logic eval;      // check the operation, set up the walk
        logic step;      // move one byte through the memory port
        logic commit;    // update pointers and count
        logic load_out;  // fill the output register
        logic cfg_we;    // take a new size, empty the buffer
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic go_xfer;   // operation moves bytes
        logic last;      // current step is the final byte
        logic out_free;  // output register can take a result
    } t_stat;

endpackage

>>> src/byte_ring_buffer_chunked_top.sv
// Each operation moves n bytes (n = bytes moved, 1..8, or none) one byte per cycle
// through the byte-wide memory port, plus evaluate, drain (only when bytes move),
// update, report and idle steps; one operation is in flight at a time, and report
// waits on a stalled result.
// A new input beat is taken while the previous result waits in the output register.
// Reset (i_rst_n low, synchronous): buffer empty, size 1024, memory kept, no result.
module byte_ring_buffer_chunked_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_mode,
    input  logic [brb_pkg::CNT_W-1:0]   i_length,
    input  logic [brb_pkg::DATA_W-1:0]  i_write_bytes,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_accepted,
    output logic [brb_pkg::DATA_W-1:0]  o_read_bytes,
    output logic [brb_pkg::CNT_W-1:0]   o_used_count,
    output logic [brb_pkg::CNT_W-1:0]   o_free_count,
    output logic [brb_pkg::CNT_W-1:0]   o_contiguous_write,
    output logic [brb_pkg::CNT_W-1:0]   o_contiguous_read,
    output logic                        o_is_empty,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [brb_pkg::CNT_W-1:0]   i_cfg_data
);

    brb_pkg::t_cmd  cmd;
    brb_pkg::t_stat stat;

    // Sequencer
    brb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready)
    );

    // Storage, pointers and result register
    brb_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_data         (i_cfg_data),
        .i_mode             (i_mode),
        .i_length           (i_length),
        .i_write_bytes      (i_write_bytes),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_accepted         (o_accepted),
        .o_read_bytes       (o_read_bytes),
        .o_used_count       (o_used_count),
        .o_free_count       (o_free_count),
        .o_contiguous_write (o_contiguous_write),
        .o_contiguous_read  (o_contiguous_read),
        .o_is_empty         (o_is_empty)
    );

endmodule

>>> src/brb_ctrl.sv
module brb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_cfg_valid,
    input  brb_pkg::t_stat i_stat,
    output brb_pkg::t_cmd  o_cmd,
    output logic          o_in_stall,
    output logic          o_cfg_ready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_XFER,
        ST_DRAIN,
        ST_COMMIT,
        ST_REPORT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_idle;

    // Decode commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.capture = i_in_valid;
                o_cmd.cfg_we  = i_cfg_valid;
                if (i_in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.go_xfer ? ST_XFER : ST_COMMIT;
            end
            ST_XFER: begin
                o_cmd.step = 1'b1;
                if (i_stat.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_REPORT;
            end
            ST_REPORT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and the registered idle flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idle  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_idle  <= (n_state == ST_IDLE);
        end
    end

    assign o_in_stall  = !r_idle;
    assign o_cfg_ready = r_idle;

endmodule

>>> src/brb_datapath.sv
module brb_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  brb_pkg::t_cmd               i_cmd,
    output brb_pkg::t_stat              o_stat,
    input  logic [brb_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic [2:0]                  i_mode,
    input  logic [brb_pkg::CNT_W-1:0]   i_length,
    input  logic [brb_pkg::DATA_W-1:0]  i_write_bytes,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic                        o_accepted,
    output logic [brb_pkg::DATA_W-1:0]  o_read_bytes,
    output logic [brb_pkg::CNT_W-1:0]   o_used_count,
    output logic [brb_pkg::CNT_W-1:0]   o_free_count,
    output logic [brb_pkg::CNT_W-1:0]   o_contiguous_write,
    output logic [brb_pkg::CNT_W-1:0]   o_contiguous_read,
    output logic                        o_is_empty
);

    // Byte store
    logic [7:0] r_mem [brb_pkg::DEPTH];
    logic [7:0] r_mem_q;

    // Buffer state
    logic [brb_pkg::CNT_W-1:0] r_size;
    logic [brb_pkg::PTR_W-1:0] r_rp;
    logic [brb_pkg::PTR_W-1:0] r_wp;
    logic [brb_pkg::CNT_W-1:0] r_cnt;

    // Current operation
    logic [2:0]                  r_mode;
    logic [brb_pkg::CNT_W-1:0]   r_len;
    logic [brb_pkg::DATA_W-1:0]  r_wsh;
    logic [brb_pkg::DATA_W-1:0]  r_rbytes;
    logic                        r_ok;
    logic [brb_pkg::PTR_W-1:0]   r_ptr;
    logic [brb_pkg::IDX_W-1:0]   r_idx;
    logic                        r_rd_vld;
    logic [brb_pkg::SLOT_W-1:0]  r_rd_slot;

    // Output register
    logic r_out_valid;

    logic [brb_pkg::CNT_W-1:0] free_now;
    logic                      chunk_ok;
    logic                      ok_now;
    logic                      is_chunk_op;
    logic [brb_pkg::CNT_W-1:0] ptr_inc;
    logic [brb_pkg::PTR_W-1:0] ptr_next;
    logic [brb_pkg::SUM_W-1:0] rp_sum;
    logic [brb_pkg::SUM_W-1:0] wp_sum;
    logic [brb_pkg::PTR_W-1:0] rp_adv;
    logic [brb_pkg::PTR_W-1:0] wp_adv;
    logic [brb_pkg::CNT_W-1:0] cfg_size;
    logic [brb_pkg::CNT_W-1:0] cw;
    logic [brb_pkg::CNT_W-1:0] cr;
    logic                      is_enq;

    // Check the operation against the current occupancy
    always_comb begin
        free_now    = r_size - r_cnt;
        chunk_ok    = (r_len <= brb_pkg::CNT_W'(brb_pkg::MAX_CHUNK));
        is_enq      = (r_mode == brb_pkg::MODE_ENQ);
        is_chunk_op = is_enq || (r_mode == brb_pkg::MODE_DEQ)
                      || (r_mode == brb_pkg::MODE_PEEK);
        unique case (r_mode)
            brb_pkg::MODE_ENQ:    ok_now = chunk_ok && (r_len <= free_now);
            brb_pkg::MODE_DEQ:    ok_now = chunk_ok && (r_len <= r_cnt);
            brb_pkg::MODE_PEEK:   ok_now = chunk_ok && (r_len <= r_cnt);
            brb_pkg::MODE_SKIP:   ok_now = (r_len <= r_cnt);
            brb_pkg::MODE_COMMIT: ok_now = (r_len <= free_now);
            brb_pkg::MODE_CLEAR:  ok_now = 1'b1;
            brb_pkg::MODE_STATUS: ok_now = 1'b1;
            default:              ok_now = 1'b0;
        endcase
    end

    // Walk pointer wraps at the usable size
    always_comb begin
        ptr_inc  = brb_pkg::CNT_W'(r_ptr) + brb_pkg::CNT_W'(1);
        ptr_next = (ptr_inc == r_size) ? '0 : r_ptr + brb_pkg::PTR_W'(1);
    end

    // Advance read or write pointer by the length
    always_comb begin
        rp_sum = brb_pkg::SUM_W'(r_rp) + brb_pkg::SUM_W'(r_len);
        wp_sum = brb_pkg::SUM_W'(r_wp) + brb_pkg::SUM_W'(r_len);
        rp_adv = (rp_sum >= brb_pkg::SUM_W'(r_size))
                 ? brb_pkg::PTR_W'(rp_sum - brb_pkg::SUM_W'(r_size))
                 : brb_pkg::PTR_W'(rp_sum);
        wp_adv = (wp_sum >= brb_pkg::SUM_W'(r_size))
                 ? brb_pkg::PTR_W'(wp_sum - brb_pkg::SUM_W'(r_size))
                 : brb_pkg::PTR_W'(wp_sum);
    end

    // Clamp the configured size to 1..DEPTH
    always_comb begin
        priority if (i_cfg_data == '0) begin
            cfg_size = brb_pkg::CNT_W'(1);
        end else if (i_cfg_data > brb_pkg::CNT_W'(brb_pkg::DEPTH)) begin
            cfg_size = brb_pkg::CNT_W'(brb_pkg::DEPTH);
        end else begin
            cfg_size = i_cfg_data;
        end
    end

    // Contiguous spans before the wrap
    always_comb begin
        if (r_cnt == r_size) begin
            cw = '0;
        end else if (r_wp >= r_rp) begin
            cw = r_size - brb_pkg::CNT_W'(r_wp);
        end else begin
            cw = brb_pkg::CNT_W'(r_rp - r_wp);
        end
        if (r_cnt == '0) begin
            cr = '0;
        end else if (r_rp < r_wp) begin
            cr = brb_pkg::CNT_W'(r_wp - r_rp);
        end else begin
            cr = r_size - brb_pkg::CNT_W'(r_rp);
        end
    end

    // Memory port: one byte written or read per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            if (is_enq) begin
                r_mem[r_ptr] <= r_wsh[7:0];
            end else begin
                r_mem_q <= r_mem[r_ptr];
            end
        end
    end

    // Operation registers and byte walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_len  <= i_length;
            r_wsh  <= i_write_bytes;
        end
        if (i_cmd.eval) begin
            r_ok     <= ok_now;
            r_ptr    <= is_enq ? r_wp : r_rp;
            r_idx    <= '0;
            r_rbytes <= '0;
        end
        if (i_cmd.step) begin
            r_ptr     <= ptr_next;
            r_idx     <= r_idx + brb_pkg::IDX_W'(1);
            r_rd_slot <= brb_pkg::SLOT_W'(r_idx);
            if (is_enq) begin
                r_wsh <= r_wsh >> 8;
            end
        end
        // Place each returned byte at its slot
        if (r_rd_vld) begin
            r_rbytes[r_rd_slot*8 +: 8] <= r_mem_q;
        end
    end

    // Pointers, count, size and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= brb_pkg::CNT_W'(brb_pkg::DEPTH);
            r_rp        <= '0;
            r_wp        <= '0;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.step && !is_enq;
            if (i_cmd.cfg_we) begin
                r_size <= cfg_size;
                r_rp   <= '0;
                r_wp   <= '0;
                r_cnt  <= '0;
            end
            if (i_cmd.commit && r_ok) begin
                unique case (r_mode)
                    brb_pkg::MODE_ENQ: begin
                        r_wp  <= r_ptr;
                        r_cnt <= r_cnt + r_len;
                    end
                    brb_pkg::MODE_DEQ: begin
                        r_rp  <= r_ptr;
                        r_cnt <= r_cnt - r_len;
                    end
                    brb_pkg::MODE_SKIP: begin
                        r_rp  <= rp_adv;
                        r_cnt <= r_cnt - r_len;
                    end
                    brb_pkg::MODE_COMMIT: begin
                        r_wp  <= wp_adv;
                        r_cnt <= r_cnt + r_len;
                    end
                    brb_pkg::MODE_CLEAR: begin
                        r_rp  <= '0;
                        r_wp  <= '0;
                        r_cnt <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_accepted         <= r_ok;
            o_read_bytes       <= r_rbytes;
            o_used_count       <= r_cnt;
            o_free_count       <= free_now;
            o_contiguous_write <= cw;
            o_contiguous_read  <= cr;
            o_is_empty         <= (r_cnt == '0);
        end
    end

    assign o_stat.go_xfer  = ok_now && is_chunk_op && (r_len != '0);
    assign o_stat.last     = (r_len == brb_pkg::CNT_W'(r_idx) + brb_pkg::CNT_W'(1));
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;

endmodule

>>> src/brb_checker.sv
module brb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_accepted,
    input logic [brb_pkg::DATA_W-1:0]  o_read_bytes,
    input logic [brb_pkg::CNT_W-1:0]   o_used_count,
    input logic [brb_pkg::CNT_W-1:0]   o_free_count,
    input logic [brb_pkg::CNT_W-1:0]   o_contiguous_write,
    input logic [brb_pkg::CNT_W-1:0]   o_contiguous_read,
    input logic                        o_is_empty
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_used_count)
            && $stable(o_read_bytes) && $stable(o_accepted))
        else $error("result beat changed under stall");

    // One operation in flight: accepting a beat closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an operation is in flight");

    // Empty flag follows the count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_used_count == '0)))
        else $error("empty flag disagrees with used count");

    // Rejected operations return no data
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_accepted |-> o_read_bytes == '0)
        else $error("rejected operation returned data");

    // Contiguous spans never exceed their totals
    a_spans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_contiguous_read <= o_used_count)
            && (o_contiguous_write <= o_free_count))
        else $error("contiguous span exceeds total");

endmodule

bind byte_ring_buffer_chunked_top brb_checker u_brb_checker (.*);
